@@ hw/rtl/isd_pkg.sv @@
// isd_pkg: shared constants and types of the descending insertion sorter
// used by the interfaces, the controller, the datapath and the top level
`default_nettype none

package isd_pkg;

    // capacity of the sorted store, legal range 2 to 64
    localparam int MAX_ITEMS = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]         t_cnt;

    // controller to datapath
    typedef struct packed {
        logic ins;     // insert the accepted word into the store
        logic shift;   // move the front entry into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic last_word;  // one entry left in the store
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/isd_if.sv @@
// isd_in_if, isd_out_if: valid/ready channels of the insertion sorter
// depends on isd_pkg for the data type
`default_nettype none

interface isd_in_if;
    logic           valid;
    logic           ready;
    isd_pkg::t_data value_in;
    logic           last_in;

    modport source (output valid, output value_in, output last_in, input ready);
    modport sink   (input valid, input value_in, input last_in, output ready);
endinterface

interface isd_out_if;
    logic           valid;
    logic           ready;
    isd_pkg::t_data value_out;
    logic           last_out;
    logic           overflowed;

    modport source (output valid, output value_out, output last_out,
                    output overflowed, input ready);
    modport sink   (input valid, input value_out, input last_out,
                    input overflowed, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/isd_ctrl.sv @@
// isd_ctrl: load/drain sequencer of the insertion sorter
// depends on isd_pkg for the command and status structs
`default_nettype none

module isd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    input  wire isd_pkg::t_dp_stat i_stat,
    output      logic              o_in_ready,
    output      isd_pkg::t_dp_cmd  o_cmd
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.ins  = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_stat.out_free) begin
                    o_cmd.shift = 1'b1;
                    if (i_stat.last_word) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/isd_datapath.sv @@
// isd_datapath: row of compare cells holding the sorted store, plus output register
// depends on isd_pkg for sizes, data type and command/status structs
`default_nettype none

module isd_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire isd_pkg::t_dp_cmd  i_cmd,
    input  wire isd_pkg::t_data    i_value,
    input  wire logic              i_out_ready,
    output      isd_pkg::t_dp_stat o_stat,
    output      logic              o_out_valid,
    output      isd_pkg::t_data    o_value,
    output      logic              o_last,
    output      logic              o_overflowed
);

    isd_pkg::t_data r_store [isd_pkg::MAX_ITEMS];
    isd_pkg::t_data n_store [isd_pkg::MAX_ITEMS];
    isd_pkg::t_cnt  r_fill;
    logic           r_drop;
    logic           r_out_valid;
    isd_pkg::t_data r_out_value;
    logic           r_out_last;
    logic           r_out_ovf;

    // keep[i]: entry i is valid and not smaller than the new word
    logic [isd_pkg::MAX_ITEMS-1:0] keep;
    logic                          full;

    assign full = (r_fill == isd_pkg::t_cnt'(isd_pkg::MAX_ITEMS));

    for (genvar i = 0; i < isd_pkg::MAX_ITEMS; i++) begin : g_cell
        assign keep[i] = (isd_pkg::t_cnt'(i) < r_fill) && (r_store[i] >= i_value);

        always_comb begin
            n_store[i] = r_store[i];
            if (i_cmd.ins && !full) begin
                if (!keep[i]) begin
                    if (i == 0) begin
                        n_store[i] = i_value;
                    end else if (keep[(i == 0) ? 0 : i-1]) begin
                        n_store[i] = i_value;
                    end else begin
                        n_store[i] = r_store[(i == 0) ? 0 : i-1];
                    end
                end
            end else if (i_cmd.shift) begin
                if (i < isd_pkg::MAX_ITEMS - 1) begin
                    n_store[i] = r_store[(i < isd_pkg::MAX_ITEMS - 1) ? i+1 : i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_store[i] <= n_store[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins) begin
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_fill <= r_fill + isd_pkg::t_cnt'(1);
                end
            end else if (i_cmd.shift) begin
                r_fill <= r_fill - isd_pkg::t_cnt'(1);
                if (o_stat.last_word) begin
                    r_drop <= 1'b0;
                end
            end
            if (i_cmd.shift) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_out_value <= r_store[0];
            r_out_last  <= o_stat.last_word;
            r_out_ovf   <= r_drop;
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.last_word = (r_fill == isd_pkg::t_cnt'(1));
    assign o_out_valid      = r_out_valid;
    assign o_value          = r_out_value;
    assign o_last           = r_out_last;
    assign o_overflowed     = r_out_ovf;

endmodule

`default_nettype wire

@@ hw/rtl/insertion_sort_descending.sv @@
// insertion_sort_descending: top level of the descending insertion sorter
// depends on isd_pkg, isd_in_if/isd_out_if, isd_ctrl and isd_datapath
//
// usage
//   i_in carries one signed 32-bit word per handshake with last_in on the final
//   word of a set; o_out returns the set largest first, last_out on the smallest
//   word and overflowed on every word of a set that lost words to a full store
// throughput and draining
//   while loading, one word is accepted every cycle: a row of MAX_ITEMS compare
//   cells finds the slot and shifts the tail in the same cycle
//   after the last word, i_in.ready stays low until the store is empty, while the
//   store drains one entry a cycle into the output register whenever it is free;
//   the last word moves the sequencer into its drain state, which then loads the
//   first result into the output register; words beyond MAX_ITEMS in a set are dropped
// reset
//   synchronous, active low; empties the store and the output register, no sweep
// stall
//   while o_out.ready is low the output register holds its word and draining pauses;
//   the next set may start loading while the final result still waits
`default_nettype none

module insertion_sort_descending (
    input wire logic i_clk,
    input wire logic i_rst_n,
    isd_in_if.sink   i_in,
    isd_out_if.source o_out
);

    isd_pkg::t_dp_cmd  cmd;
    isd_pkg::t_dp_stat stat;

    // sequencer: load phase takes words, drain phase feeds the output register
    isd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_in),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // sorted store and output register
    isd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_in.value_in),
        .i_out_ready  (o_out.ready),
        .o_stat       (stat),
        .o_out_valid  (o_out.valid),
        .o_value      (o_out.value_out),
        .o_last       (o_out.last_out),
        .o_overflowed (o_out.overflowed)
    );

    // insert and drain never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.ins && cmd.shift))
        else $error("insert and drain in the same cycle");

    // draining only into a free output register
    a_shift_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.shift |-> stat.out_free)
        else $error("output register overwritten");

    // the final drained entry shows up flagged as last
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.shift && stat.last_word) |=> (o_out.valid && o_out.last_out))
        else $error("final word not flagged");

    // a set's last word starts a drain on the next cycle
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_in) |=> !i_in.ready)
        else $error("input still open after last word");

endmodule

`default_nettype wire
